@@ rtl/fspa_pkg.sv @@
// Shared types and constants for the fixed slot pool allocator.
`default_nettype none

package fspa_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned IdW     = 9;
  localparam int unsigned StatusW = 2;

  typedef enum logic [KindW-1:0] {
    KIND_PUT = 2'd0,
    KIND_GET = 2'd1,
    KIND_DEL = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD       = 2'd2
  } status_e;

endpackage

`default_nettype wire

@@ rtl/fixed_slot_pool_allocator.sv @@
// Fixed slot pool allocator: LIFO free-slot stack plus element store.
//
// Takes one request per clock (put, get or delete) and returns exactly one result, registered
// in the cycle after the request is accepted. The rate is set by the free-stack top register: a
// pop reads the next entry from the synchronous stack RAM in the same cycle, so back-to-back
// puts and deletes never stall. s_axis_tready_o drops only while a result sits in the output
// register and the sink does not take it. No clearing pass after reset: the free stack uses a
// low-water mark (entries below it still hold their reset contents) and the element store
// keeps one valid bit per slot, so the block is ready from the first cycle after reset.
// Slot ids are 1-based; a put on an empty stack reports exhausted, a bad id, an undefined
// kind or a delete on a full stack reports bad id.
`default_nettype none

module fixed_slot_pool_allocator #(
  parameter int unsigned CAPACITY     = 256,
  parameter int unsigned ELEMENT_BITS = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  // tuser: kind[1:0]
  input  wire logic [fspa_pkg::KindW-1:0]               s_axis_tuser_i,
  // tdata: slot_id[8:0], data_in[ELEMENT_BITS+8:9], zero padding above
  input  wire logic [((fspa_pkg::IdW+ELEMENT_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input  wire logic                                     s_axis_tvalid_i,
  output logic                                          s_axis_tready_o,
  // tdata: slot_out[8:0], data_out[ELEMENT_BITS+8:9], status[ELEMENT_BITS+10:ELEMENT_BITS+9],
  //        zero padding above
  output logic [((fspa_pkg::IdW+ELEMENT_BITS+fspa_pkg::StatusW+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                                          m_axis_tvalid_o,
  input  wire logic                                     m_axis_tready_i
);

  localparam int unsigned IdxW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW    = $clog2(CAPACITY + 1);
  localparam int unsigned OutW    = fspa_pkg::IdW + ELEMENT_BITS + fspa_pkg::StatusW;
  localparam int unsigned OutBytW = ((OutW + 7) / 8) * 8;

  // request fields
  fspa_pkg::kind_e           kind;
  logic [fspa_pkg::IdW-1:0]  id;
  logic [ELEMENT_BITS-1:0]   din;
  logic                      id_ok;
  logic [IdxW-1:0]           id_idx;
  logic                      accept;

  // free stack
  logic [IdxW-1:0] stk_mem [CAPACITY];
  logic [IdxW-1:0] stk_rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] low_q, low_d;
  logic [IdxW-1:0] top_val_q, top_val_d;
  logic            top_mem_q, top_mem_d;
  logic [IdxW-1:0] top_idx;
  logic            push, pop_rd;

  // element store
  logic [ELEMENT_BITS-1:0] elem_mem [CAPACITY];
  logic [ELEMENT_BITS-1:0] elem_rd_q;
  logic [CAPACITY-1:0]     elem_vld_q;
  logic                    rd_vld_q;
  logic                    elem_we, get_rd;

  // result register
  logic                     out_vld_q;
  logic [fspa_pkg::IdW-1:0] slot_q, res_slot;
  fspa_pkg::status_e        status_q, res_status;
  logic                     get_q, res_get;
  logic [ELEMENT_BITS-1:0]  data_out;

  assign s_axis_tready_o = ~out_vld_q | m_axis_tready_i;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  assign kind   = fspa_pkg::kind_e'(s_axis_tuser_i);
  assign id     = s_axis_tdata_i[fspa_pkg::IdW-1:0];
  assign din    = s_axis_tdata_i[fspa_pkg::IdW +: ELEMENT_BITS];
  assign id_ok  = (id != '0) && (32'(id) <= 32'(CAPACITY));
  assign id_idx = IdxW'(32'(id) - 32'd1);

  // top of stack is either a value held in flops or the last RAM read
  assign top_idx = top_mem_q ? stk_rd_q : top_val_q;

  always_comb begin
    cnt_d      = cnt_q;
    low_d      = low_q;
    top_val_d  = top_val_q;
    top_mem_d  = top_mem_q;
    push       = 1'b0;
    pop_rd     = 1'b0;
    elem_we    = 1'b0;
    get_rd     = 1'b0;
    res_slot   = '0;
    res_status = fspa_pkg::ST_BAD;
    res_get    = 1'b0;
    if (accept) begin
      unique case (kind)
        fspa_pkg::KIND_PUT: begin
          if (cnt_q == '0) begin
            res_status = fspa_pkg::ST_EXHAUSTED;
          end else begin
            cnt_d = cnt_q - 1'b1;
            low_d = (cnt_d < low_q) ? cnt_d : low_q;
            if (cnt_q > CntW'(1)) begin
              // new top below the low-water mark was never rewritten
              if (low_d == cnt_d) begin
                top_val_d = IdxW'(32'(CAPACITY) + 32'd1 - 32'(cnt_q));
                top_mem_d = 1'b0;
              end else begin
                pop_rd    = 1'b1;
                top_mem_d = 1'b1;
              end
            end
            elem_we    = 1'b1;
            res_slot   = fspa_pkg::IdW'(32'(top_idx) + 32'd1);
            res_status = fspa_pkg::ST_OK;
          end
        end
        fspa_pkg::KIND_GET: begin
          if (id_ok) begin
            get_rd     = 1'b1;
            res_get    = 1'b1;
            res_slot   = id;
            res_status = fspa_pkg::ST_OK;
          end
        end
        fspa_pkg::KIND_DEL: begin
          if (id_ok && (32'(cnt_q) < 32'(CAPACITY))) begin
            push       = 1'b1;
            cnt_d      = cnt_q + 1'b1;
            top_val_d  = id_idx;
            top_mem_d  = 1'b0;
            res_slot   = id;
            res_status = fspa_pkg::ST_OK;
          end
        end
        default: begin
          res_status = fspa_pkg::ST_BAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= CntW'(CAPACITY);
      low_q      <= CntW'(CAPACITY);
      top_val_q  <= '0;
      top_mem_q  <= 1'b0;
      elem_vld_q <= '0;
      out_vld_q  <= 1'b0;
      get_q      <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      low_q     <= low_d;
      top_val_q <= top_val_d;
      top_mem_q <= top_mem_d;
      if (elem_we) begin
        elem_vld_q[top_idx] <= 1'b1;
      end
      if (get_rd) begin
        rd_vld_q <= elem_vld_q[id_idx];
      end
      if (accept) begin
        out_vld_q <= 1'b1;
        get_q     <= res_get;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q   <= res_slot;
      status_q <= res_status;
    end
  end

  // free stack RAM: write on delete, read ahead on pop
  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_mem[IdxW'(cnt_q)] <= id_idx;
    end
    if (pop_rd) begin
      stk_rd_q <= stk_mem[IdxW'(32'(cnt_q) - 32'd2)];
    end
  end

  // element store RAM
  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[top_idx] <= din;
    end
    if (get_rd) begin
      elem_rd_q <= elem_mem[id_idx];
    end
  end

  assign data_out        = (get_q && rd_vld_q) ? elem_rd_q : '0;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OutBytW'({status_q, data_out, slot_q});

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(CAPACITY))
    else $error("free count above capacity");

  a_low_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= cnt_q)
    else $error("low-water mark above free count");

  a_put_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (kind == fspa_pkg::KIND_PUT) && (cnt_q != '0) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("put did not pop the free stack");

  a_del_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> top_idx == $past(id_idx))
    else $error("deleted slot is not on top of the free stack");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_vld_q)
    else $error("accepted request left no result");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the fixed slot pool allocator: driver, sink and pool predictor.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KindW    = fspa_pkg::KindW;
  localparam int unsigned IdW      = fspa_pkg::IdW;
  localparam int unsigned StatusW  = fspa_pkg::StatusW;
  localparam int unsigned Capacity = 256;
  localparam int unsigned ElemW    = 64;
  localparam int unsigned InW      = ((IdW + ElemW + 7) / 8) * 8;
  localparam int unsigned OutW     = ((IdW + ElemW + StatusW + 7) / 8) * 8;
  localparam logic [KindW-1:0] KIND_UNDEF = 2'd3;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   slot_id;
    logic [ElemW-1:0] data;
  } pool_req_t;

  typedef struct packed {
    logic [IdW-1:0]     slot;
    logic [ElemW-1:0]   data;
    logic [StatusW-1:0] status;
  } pool_rsp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic [KindW-1:0]  s_axis_tuser_i = '0;
  logic [InW-1:0]    s_axis_tdata_i = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [OutW-1:0]   m_axis_tdata_o;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;

  fixed_slot_pool_allocator #(
    .CAPACITY    (Capacity),
    .ELEMENT_BITS(ElemW)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: free-slot stack, its fill level and the element words.
  logic [7:0]       free_stk [Capacity];
  logic [IdW-1:0]   free_cnt;
  logic [ElemW-1:0] elem_mem [Capacity];

  pool_req_t req_q [$];
  pool_rsp_t rsp_q [$];
  int        req_total;
  int        req_cnt = 0;
  int        err_cnt = 0;
  logic      req_fire = 1'b0;

  function automatic pool_rsp_t pool_apply(pool_req_t req);
    pool_rsp_t  rsp;
    logic [7:0] idx;
    logic       id_ok;
    rsp    = '{slot: '0, data: '0, status: fspa_pkg::ST_BAD};
    id_ok  = req.slot_id >= 1 && req.slot_id <= Capacity;
    case (req.kind)
      fspa_pkg::KIND_PUT: begin
        if (free_cnt == 0) begin
          rsp.status = fspa_pkg::ST_EXHAUSTED;
        end else begin
          free_cnt      = free_cnt - 1'b1;
          idx           = free_stk[8'(free_cnt)];
          elem_mem[idx] = req.data;
          rsp.slot      = IdW'(idx) + 1'b1;
          rsp.status    = fspa_pkg::ST_OK;
        end
      end
      fspa_pkg::KIND_GET: begin
        if (id_ok) begin
          rsp.data   = elem_mem[8'(req.slot_id - 1'b1)];
          rsp.slot   = req.slot_id;
          rsp.status = fspa_pkg::ST_OK;
        end
      end
      fspa_pkg::KIND_DEL: begin
        if (id_ok && free_cnt < Capacity) begin
          free_stk[8'(free_cnt)] = 8'(req.slot_id - 1'b1);
          free_cnt               = free_cnt + 1'b1;
          rsp.slot               = req.slot_id;
          rsp.status             = fspa_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Request driver: changes on the falling edge, holds an offer until it is taken.
  int sender_gap = 0;
  int burst_left = 0;

  always @(negedge clk_i) begin
    pool_req_t req;
    int        r;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (s_axis_tvalid_i && !req_fire) begin
      // offer still pending
    end else if (sender_gap > 0) begin
      sender_gap--;
      s_axis_tvalid_i <= 1'b0;
    end else if (req_q.size() > 0) begin
      req = req_q.pop_front();
      s_axis_tuser_i  <= req.kind;
      s_axis_tdata_i  <= {(InW - IdW - ElemW)'(0), req.data, req.slot_id};
      s_axis_tvalid_i <= 1'b1;
      r = $urandom_range(0, 99);
      if (burst_left > 0) begin
        burst_left--;
        sender_gap = 0;
      end else if (r < 3) begin
        burst_left = $urandom_range(20, 80);
        sender_gap = 0;
      end else if (r < 50) begin
        sender_gap = 0;
      end else if (r < 90) begin
        sender_gap = $urandom_range(1, 3);
      end else begin
        sender_gap = $urandom_range(5, 30);
      end
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  // Result sink: random stalls, plus one long hold-off while requests keep coming.
  int  sink_hold = 0;
  bit  held_off  = 1'b0;

  always @(negedge clk_i) begin
    int r;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (!held_off && req_cnt >= 400) begin
      held_off = 1'b1;
      sink_hold = 200;
      m_axis_tready_i <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready_i <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b0;
        sink_hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 25);
      end
    end
  end

  // Monitor: check results first, then predict the request taken at this edge.
  always @(posedge clk_i) begin
    pool_rsp_t want;
    pool_rsp_t got;
    pool_req_t req;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.slot   = m_axis_tdata_o[IdW-1:0];
      got.data   = m_axis_tdata_o[IdW+ElemW-1:IdW];
      got.status = m_axis_tdata_o[IdW+ElemW+StatusW-1:IdW+ElemW];
      if (rsp_q.size() == 0) begin
        $error("result with no request outstanding: tdata %h", m_axis_tdata_o);
        err_cnt++;
      end else begin
        want = rsp_q.pop_front();
        if (got.slot !== want.slot) begin
          $error("slot_out: expected %0d, got %0d", want.slot, got.slot);
          err_cnt++;
        end
        if (got.data !== want.data) begin
          $error("data_out: expected %h, got %h", want.data, got.data);
          err_cnt++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_cnt++;
        end
        if (m_axis_tdata_o[OutW-1:IdW+ElemW+StatusW] !== '0) begin
          $error("padding: expected 0, got %h", m_axis_tdata_o[OutW-1:IdW+ElemW+StatusW]);
          err_cnt++;
        end
      end
    end
    req_fire <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      req.kind    = s_axis_tuser_i;
      req.slot_id = s_axis_tdata_i[IdW-1:0];
      req.data    = s_axis_tdata_i[IdW+ElemW-1:IdW];
      rsp_q.push_back(pool_apply(req));
      req_cnt++;
    end
  end

  function automatic logic [ElemW-1:0] rand_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  function automatic pool_req_t mk_req(logic [KindW-1:0] kind, int id, logic [ElemW-1:0] data);
    pool_req_t req;
    req.kind    = kind;
    req.slot_id = IdW'(id);
    req.data    = data;
    return req;
  endfunction

  // One random request; mode 0 drains the pool, 1 refills it, 2 is mixed.
  function automatic pool_req_t rand_req(int mode);
    int r;
    int id;
    r  = $urandom_range(0, 99);
    id = $urandom_range(1, Capacity);
    if (r < 3) begin
      // malformed: undefined kind, or an id outside the pool
      if ($urandom_range(0, 1)) return mk_req(KIND_UNDEF, $urandom_range(0, 511), rand_word());
      id = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(Capacity + 1, 511);
      return mk_req($urandom_range(0, 1) ? fspa_pkg::KIND_GET : fspa_pkg::KIND_DEL, id,
                    rand_word());
    end
    case (mode)
      0:       r = (r < 83) ? 0 : (r < 93) ? 1 : 2;
      1:       r = (r < 18) ? 0 : (r < 31) ? 1 : 2;
      default: r = (r < 43) ? 0 : (r < 68) ? 1 : 2;
    endcase
    case (r)
      0:       return mk_req(fspa_pkg::KIND_PUT, $urandom_range(0, 511), rand_word());
      1:       return mk_req(fspa_pkg::KIND_GET, id, rand_word());
      default: return mk_req(fspa_pkg::KIND_DEL, id, rand_word());
    endcase
  endfunction

  initial begin
    int mode;
    int len;
    for (int i = 0; i < Capacity; i++) begin
      free_stk[i] = 8'(Capacity - 1 - i);
      elem_mem[i] = '0;
    end
    free_cnt = IdW'(Capacity);

    // directed: unwritten reads, bad ids, overflow, undefined kind, reuse of freed slots
    req_q.push_back(mk_req(fspa_pkg::KIND_GET, 1, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_GET, 0, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_GET, Capacity + 1, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_GET, 511, '1));
    req_q.push_back(mk_req(fspa_pkg::KIND_DEL, 5, '0));
    req_q.push_back(mk_req(KIND_UNDEF, 3, '1));
    req_q.push_back(mk_req(fspa_pkg::KIND_PUT, 0, '1));
    req_q.push_back(mk_req(fspa_pkg::KIND_PUT, 511, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_PUT, 7, 64'hA5A5_5A5A_0123_4567));
    req_q.push_back(mk_req(fspa_pkg::KIND_GET, 1, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_GET, Capacity, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_GET, 3, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_DEL, 2, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_DEL, 2, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_PUT, 0, 64'h8000_0000_0000_0001));
    req_q.push_back(mk_req(fspa_pkg::KIND_PUT, 0, 64'h7FFF_FFFF_FFFF_FFFE));
    req_q.push_back(mk_req(fspa_pkg::KIND_GET, 2, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_DEL, Capacity, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_PUT, 0, 64'hDEAD_BEEF_CAFE_F00D));
    req_q.push_back(mk_req(fspa_pkg::KIND_GET, Capacity, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_DEL, 0, '0));
    req_q.push_back(mk_req(fspa_pkg::KIND_DEL, 1, '0));

    // a long draining phase first so the pool runs dry, then random phases
    for (int i = 0; i < 400; i++) req_q.push_back(rand_req(0));
    while (req_q.size() < 1200) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(100, 250);
      for (int i = 0; i < len && req_q.size() < 1200; i++) req_q.push_back(rand_req(mode));
    end
    req_total = req_q.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_cnt != req_total || rsp_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
